// ----- rtl/rgig_pkg.sv -----
// Shared widths, command codes and register indexes for the row gather index generator.
package rgig_pkg;

  localparam int CMD_W            = 2;
  localparam int SLOT_W           = 8;
  localparam int VALUE_W          = 16;
  localparam int ROW_COUNT_W      = 9;
  localparam int COUNT_W          = 16;
  localparam int STRIDE_W         = 16;
  localparam int ADDR_W           = 32;
  localparam int CFG_INDEX_W      = 2;
  localparam int CFG_DATA_W       = 16;
  localparam int MAX_ROWS_DEFAULT = 256;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD         = 2'd0,
    CMD_RESTART      = 2'd1,
    CMD_NEXT_ELEMENT = 2'd2,
    CMD_NEXT_ROW     = 2'd3
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ROW_COUNT     = 2'd0,
    CFG_COLUMN_COUNT  = 2'd1,
    CFG_ROW_STRIDE    = 2'd2,
    CFG_COLUMN_STRIDE = 2'd3
  } cfg_index_t;

endpackage

// ----- rtl/row_gather_index_generator_core.sv -----
// Row gather address generator: walks element addresses over a listed set of rows.
//
//   channel   signals                                   beat carries
//   --------  ----------------------------------------  ------------------------------
//   input     in_valid / in_stall (driven here)         command, row_slot, row_value
//   output    out_valid / out_stall (driven by sink)    active, address, loop_extent,
//                                                       loop_stride
//   config    cfg_valid / cfg_ready (always ready)      cfg_index, cfg_data
//
// One input beat is taken every cycle that in_stall is low; a result appears in the
// output register in the cycle after its command beat. The step is one 17x16 multiply
// (row start) or one 32-bit add (column step) feeding the walk registers.
// Reset leaves the walk finished; no clearing pass runs, the row table is undefined
// until loaded. in_stall is high only while a result sits in the output register
// and the sink stalls it.
module row_gather_index_generator_core #(
  parameter int MAX_ROWS = rgig_pkg::MAX_ROWS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [rgig_pkg::CMD_W-1:0]           command,
  input  logic [rgig_pkg::SLOT_W-1:0]          row_slot,
  input  logic [rgig_pkg::VALUE_W-1:0]         row_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 active,
  output logic signed [rgig_pkg::ADDR_W-1:0]   address,
  output logic [rgig_pkg::COUNT_W-1:0]         loop_extent,
  output logic signed [rgig_pkg::STRIDE_W-1:0] loop_stride,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rgig_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rgig_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import rgig_pkg::*;

  // Row index width, and a count width that can also hold MAX_ROWS itself.
  localparam int RowW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int UsedW  = ($clog2(MAX_ROWS + 1) > ROW_COUNT_W) ?
                          $clog2(MAX_ROWS + 1) : ROW_COUNT_W;
  localparam int SlotXW = (RowW > SLOT_W) ? RowW : SLOT_W;

  // Configuration registers
  logic [ROW_COUNT_W-1:0]     row_count;
  logic [COUNT_W-1:0]         column_count;
  logic signed [STRIDE_W-1:0] row_stride;
  logic signed [STRIDE_W-1:0] column_stride;

  // Row table and its prefetch registers. row_next_value always holds the entry
  // for the row after the current one, so a row change needs no read latency.
  // row0_value mirrors entry zero for restart.
  logic [VALUE_W-1:0] row_table [MAX_ROWS];
  logic [VALUE_W-1:0] row_next_value;
  logic [VALUE_W-1:0] row0_value;

  // Walk state
  logic [RowW-1:0]   row_position,    row_position_next;
  logic [COUNT_W-1:0] column_position, column_position_next;
  logic [ADDR_W-1:0] current_address, current_address_next;
  logic              finished,        finished_next;

  logic               in_fire;
  cmd_t               cmd;
  logic [UsedW-1:0]   used_rows;
  logic [UsedW-1:0]   row_after;
  logic               last_row;
  logic [COUNT_W:0]   col_after;
  logic               row_end;
  logic [VALUE_W-1:0] mul_operand;
  logic signed [ADDR_W:0] product;
  logic [ADDR_W-1:0]  row_start;
  logic [ADDR_W-1:0]  column_step;
  logic               produces;
  logic [SlotXW-1:0]  slot_ext;
  logic               wr_en;
  logic [RowW-1:0]    wr_addr;
  logic [RowW-1:0]    rd_addr;

  // Handshakes: the output register frees itself when the sink takes its beat.
  assign in_stall  = out_valid && out_stall;
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cmd       = cmd_t'(command);

  // Rows in use are capped at the table depth.
  assign used_rows = (UsedW'(row_count) > UsedW'(MAX_ROWS)) ? UsedW'(MAX_ROWS)
                                                            : UsedW'(row_count);
  assign row_after = UsedW'(row_position) + UsedW'(1);
  assign last_row  = row_after >= used_rows;

  // A column count of zero still ends the row after one element.
  assign col_after = {1'b0, column_position} + (COUNT_W + 1)'(1);
  assign row_end   = col_after >= {1'b0, column_count};

  // One shared multiplier: restart scales entry zero, a row change scales the
  // prefetched next entry. Keep the low 32 bits of the product.
  assign mul_operand = (cmd == CMD_RESTART) ? row0_value : row_next_value;
  assign product     = $signed({1'b0, mul_operand}) * row_stride;
  assign row_start   = product[ADDR_W-1:0];
  assign column_step = ADDR_W'(column_stride);

  always_comb begin
    row_position_next    = row_position;
    column_position_next = column_position;
    current_address_next = current_address;
    finished_next        = finished;
    if (in_fire) begin
      case (cmd)
        CMD_RESTART: begin
          row_position_next    = '0;
          column_position_next = '0;
          if (used_rows == '0 || column_count == '0) begin
            finished_next = 1'b1;
          end else begin
            finished_next        = 1'b0;
            current_address_next = row_start;
          end
        end
        CMD_NEXT_ELEMENT: begin
          if (!finished) begin
            if (row_end) begin
              column_position_next = '0;
              if (last_row) begin
                finished_next = 1'b1;
              end else begin
                row_position_next    = row_after[RowW-1:0];
                current_address_next = row_start;
              end
            end else begin
              column_position_next = col_after[COUNT_W-1:0];
              current_address_next = current_address + column_step;
            end
          end
        end
        CMD_NEXT_ROW: begin
          if (!finished) begin
            if (last_row) begin
              finished_next = 1'b1;
            end else begin
              row_position_next    = row_after[RowW-1:0];
              current_address_next = row_start;
            end
          end
        end
        default: begin
          // Loads touch only the table.
        end
      endcase
    end
  end

  assign produces = in_fire && (cmd == CMD_NEXT_ELEMENT || cmd == CMD_NEXT_ROW);

  // Table port: one write, one read that tracks the row after the next position.
  assign slot_ext = SlotXW'(row_slot);
  assign wr_en    = in_fire && (cmd == CMD_LOAD) && (32'(row_slot) < 32'(MAX_ROWS));
  assign wr_addr  = slot_ext[RowW-1:0];
  assign rd_addr  = rst ? RowW'(1) : row_position_next + RowW'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_table[wr_addr] <= row_value;
    end
    // Forward a write that lands on the entry being fetched.
    if (wr_en && wr_addr == rd_addr) begin
      row_next_value <= row_value;
    end else begin
      row_next_value <= row_table[rd_addr];
    end
    if (wr_en && wr_addr == '0) begin
      row0_value <= row_value;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count     <= '0;
      column_count  <= '0;
      row_stride    <= '0;
      column_stride <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_ROW_COUNT:     row_count     <= cfg_data[ROW_COUNT_W-1:0];
        CFG_COLUMN_COUNT:  column_count  <= cfg_data[COUNT_W-1:0];
        CFG_ROW_STRIDE:    row_stride    <= $signed(cfg_data[STRIDE_W-1:0]);
        CFG_COLUMN_STRIDE: column_stride <= $signed(cfg_data[STRIDE_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  // Walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      row_position    <= '0;
      column_position <= '0;
      current_address <= '0;
      finished        <= 1'b1;
    end else begin
      row_position    <= row_position_next;
      column_position <= column_position_next;
      current_address <= current_address_next;
      finished        <= finished_next;
    end
  end

  // Output register: load on a producing beat, drop when the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= produces;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Finished walks report an inactive beat with all fields at zero.
  always_ff @(posedge clk) begin
    if (produces) begin
      active      <= !finished;
      address     <= finished ? '0 : $signed(current_address);
      loop_extent <= (!finished && cmd == CMD_NEXT_ROW) ? column_count : '0;
      loop_stride <= (!finished && cmd == CMD_NEXT_ROW) ? column_stride : '0;
    end
  end

endmodule

// ----- rtl/rgig_checker.sv -----
// Port-level checks for the row gather index generator, bound to its top level.
module rgig_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic [rgig_pkg::CMD_W-1:0]           command,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic                                 active,
  input logic signed [rgig_pkg::ADDR_W-1:0]   address,
  input logic [rgig_pkg::COUNT_W-1:0]         loop_extent,
  input logic signed [rgig_pkg::STRIDE_W-1:0] loop_stride
);
  import rgig_pkg::*;

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(address) && $stable(active))
    else $error("stalled result beat changed or dropped");

  // Stall the input only behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // Load and restart beats yield no result.
  a_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall &&
    (cmd_t'(command) == CMD_LOAD || cmd_t'(command) == CMD_RESTART) |=> !out_valid)
    else $error("result appeared for a load or restart");

  // An inactive beat carries zero fields.
  a_inactive_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !active |-> address == '0 && loop_extent == '0 && loop_stride == '0)
    else $error("inactive result with nonzero fields");

endmodule

bind row_gather_index_generator_core rgig_checker u_rgig_checker (.*);

// ----- tb/tb.sv -----
// Self-checking testbench for the row gather address generator core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgig_pkg::*;

  localparam int TABLE_DEPTH = MAX_ROWS_DEFAULT;

  // One result beat as the block presents it.
  typedef struct packed {
    logic              active;
    logic [ADDR_W-1:0] address;
    logic [COUNT_W-1:0] extent;
    logic [STRIDE_W-1:0] stride;
  } walk_result_t;

  // Scoreboard: keeps its own copy of the walk and the table, predicts the
  // result of every accepted command and checks result beats in order.
  class row_walk_scoreboard;
    logic [VALUE_W-1:0]     row_table [TABLE_DEPTH];
    bit                     row_loaded [TABLE_DEPTH];
    int unsigned            row_pos;
    int unsigned            col_pos;
    logic [ADDR_W-1:0]      walk_addr;
    bit                     walk_done;
    logic [ROW_COUNT_W-1:0] row_count;
    logic [COUNT_W-1:0]     column_count;
    logic [STRIDE_W-1:0]    row_stride;
    logic [STRIDE_W-1:0]    column_stride;
    walk_result_t           expected_results [$];
    int unsigned            mismatches;

    function new();
      row_pos       = 0;
      col_pos       = 0;
      walk_addr     = '0;
      walk_done     = 1'b1;
      row_count     = '0;
      column_count  = '0;
      row_stride    = '0;
      column_stride = '0;
      mismatches    = 0;
    endfunction

    function int unsigned rows_in_use();
      return (row_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(row_count);
    endfunction

    // Start address of listed row r; wraps at 32 bits.
    function logic [ADDR_W-1:0] row_base(int unsigned r);
      logic [ADDR_W-1:0] rownum;
      rownum = (r < TABLE_DEPTH) ? {16'b0, row_table[r]} : '0;
      return rownum * {{16{row_stride[STRIDE_W-1]}}, row_stride};
    endfunction

    function void step_row();
      if (row_pos + 1 >= rows_in_use()) begin
        walk_done = 1'b1;
      end else begin
        row_pos   = row_pos + 1;
        walk_addr = row_base(row_pos);
      end
    endfunction

    function void set_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ROW_COUNT:     row_count     = data[ROW_COUNT_W-1:0];
        CFG_COLUMN_COUNT:  column_count  = data;
        CFG_ROW_STRIDE:    row_stride    = data;
        CFG_COLUMN_STRIDE: column_stride = data;
        default: ;
      endcase
    endfunction

    function void note_command(cmd_t cmd, logic [SLOT_W-1:0] slot,
                               logic [VALUE_W-1:0] value);
      walk_result_t res;
      res = '0;
      case (cmd)
        CMD_LOAD: begin
          row_table[slot]  = value;
          row_loaded[slot] = 1'b1;
        end
        CMD_RESTART: begin
          row_pos = 0;
          col_pos = 0;
          if (rows_in_use() == 0 || column_count == 0) begin
            walk_done = 1'b1;
          end else begin
            walk_done = 1'b0;
            walk_addr = row_base(0);
          end
        end
        default: begin
          if (!walk_done) begin
            res.active  = 1'b1;
            res.address = walk_addr;
            if (cmd == CMD_NEXT_ELEMENT) begin
              if (col_pos + 1 >= column_count) begin
                col_pos = 0;
                step_row();
              end else begin
                col_pos   = col_pos + 1;
                walk_addr = walk_addr + {{16{column_stride[STRIDE_W-1]}}, column_stride};
              end
            end else begin
              res.extent = column_count;
              res.stride = column_stride;
              step_row();
            end
          end
          expected_results.push_back(res);
        end
      endcase
    endfunction

    function void check_result(logic act, logic [ADDR_W-1:0] addr,
                               logic [COUNT_W-1:0] ext, logic [STRIDE_W-1:0] strd);
      walk_result_t want;
      if (expected_results.size() == 0) begin
        $error("result beat arrived with no command waiting for it");
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      if (act !== want.active) begin
        $error("active: expected %0b, got %0b", want.active, act);
        mismatches++;
      end
      if (addr !== want.address) begin
        $error("address: expected %h, got %h", want.address, addr);
        mismatches++;
      end
      if (ext !== want.extent) begin
        $error("loop_extent: expected %h, got %h", want.extent, ext);
        mismatches++;
      end
      if (strd !== want.stride) begin
        $error("loop_stride: expected %h, got %h", want.stride, strd);
        mismatches++;
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid;
  logic                    in_stall;
  logic [CMD_W-1:0]        command;
  logic [SLOT_W-1:0]       row_slot;
  logic [VALUE_W-1:0]      row_value;
  logic                    out_valid;
  logic                    out_stall;
  logic                    active;
  logic signed [ADDR_W-1:0]   address;
  logic [COUNT_W-1:0]      loop_extent;
  logic signed [STRIDE_W-1:0] loop_stride;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_INDEX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  // Idle burst odds for both sides: one chance in idle_odds per beat or
  // cycle; zero turns idling off entirely.
  int unsigned idle_odds = 0;

  row_walk_scoreboard sb;

  row_gather_index_generator_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .row_slot   (row_slot),
    .row_value  (row_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .active     (active),
    .address    (address),
    .loop_extent(loop_extent),
    .loop_stride(loop_stride),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // Sink side: stall the result channel in short random bursts. All stall
  // changes land on a rising edge so the monitor below sees the value that
  // the block saw at that edge.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Result monitor: a beat moves on each edge with valid high and stall low.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_result(active, address, loop_extent, loop_stride);
  end

  // Drive one command beat and hold it until the block takes it. An idle
  // burst may come first; valid is lowered only here and raised again on a
  // later edge, so valid never toggles twice within one step.
  task automatic send_item(cmd_t cmd, logic [SLOT_W-1:0] slot, logic [VALUE_W-1:0] value);
    if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    row_slot  <= slot;
    row_value <= value;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_command(cmd, slot, value);
  endtask

  // Drop valid, wait until every predicted result has been seen, and then let
  // the block settle in case a load or restart is still in flight.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all four registers back to back; valid stays high across the burst.
  task automatic write_config(logic [ROW_COUNT_W-1:0] rows, logic [COUNT_W-1:0] cols,
                              logic [STRIDE_W-1:0] rstride, logic [STRIDE_W-1:0] cstride);
    cfg_index_t       order [4];
    logic [CFG_DATA_W-1:0] vals [4];
    order = '{CFG_ROW_COUNT, CFG_COLUMN_COUNT, CFG_ROW_STRIDE, CFG_COLUMN_STRIDE};
    vals  = '{{7'b0, rows}, cols, rstride, cstride};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      sb.set_register(order[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Load every listed row that has never been written, so that no walk step
  // ever reads an undefined table entry.
  task automatic fill_rows();
    for (int r = 0; r < sb.rows_in_use(); r++)
      if (!sb.row_loaded[r])
        send_item(CMD_LOAD, SLOT_W'(r), VALUE_W'($urandom()));
  endtask

  // Random part of one setting: mostly restart followed by a run of steps,
  // with stray single commands and loads mixed in as noise.
  task automatic random_walks(int unsigned budget);
    int unsigned sent;
    int unsigned walk_cap;
    int unsigned len;
    cmd_t        cmd;
    sent     = 0;
    walk_cap = sb.rows_in_use() * ((sb.column_count == 0) ? 1 : sb.column_count) + 3;
    if (walk_cap > 150) walk_cap = 150;
    while (sent < budget) begin
      if ($urandom_range(0, 5) == 0) begin
        send_item(cmd_t'($urandom_range(0, 3)), SLOT_W'($urandom()), VALUE_W'($urandom()));
        sent++;
      end else begin
        send_item(CMD_RESTART, SLOT_W'($urandom()), VALUE_W'($urandom()));
        len = $urandom_range(1, walk_cap);
        // Stop the last walk at the budget.
        if (len + 1 > budget - sent) len = budget - sent - 1;
        for (int i = 0; i < len; i++) begin
          cmd = ($urandom_range(0, 3) == 0) ? CMD_NEXT_ROW : CMD_NEXT_ELEMENT;
          send_item(cmd, SLOT_W'($urandom()), VALUE_W'($urandom()));
        end
        sent += len + 1;
      end
    end
  endtask

  // One setting: idle the block, reprogram it, fill the table and walk.
  task automatic run_phase(logic [ROW_COUNT_W-1:0] rows, logic [COUNT_W-1:0] cols,
                           logic [STRIDE_W-1:0] rstride, logic [STRIDE_W-1:0] cstride,
                           int unsigned budget, int unsigned odds);
    drain();
    idle_odds = odds;
    write_config(rows, cols, rstride, cstride);
    fill_rows();
    random_walks(budget);
  endtask

  initial begin
    sb = new();
    in_valid  <= 1'b0;
    command   <= CMD_LOAD;
    row_slot  <= '0;
    row_value <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_ROW_COUNT;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    idle_odds = 3;

    // Out of reset the walk is finished: steps answer inactive, and a
    // restart with no rows configured leaves it finished.
    send_item(CMD_NEXT_ELEMENT, '0, '0);
    send_item(CMD_NEXT_ROW, '1, '1);
    send_item(CMD_RESTART, '0, '0);
    send_item(CMD_NEXT_ELEMENT, '0, '0);

    // Table corners: first and last slot, all-zero and all-one row numbers.
    send_item(CMD_LOAD, 8'd0, 16'hFFFF);
    send_item(CMD_LOAD, 8'd1, 16'h0000);
    send_item(CMD_LOAD, 8'd2, 16'h1234);
    send_item(CMD_LOAD, 8'd255, 16'hFFFF);

    // Three rows of two: walk to the end and past it, with the most
    // negative row stride and the most positive column stride.
    drain();
    write_config(9'd3, 16'd2, 16'h8000, 16'h7FFF);
    send_item(CMD_RESTART, '0, '0);
    send_item(CMD_NEXT_ELEMENT, '0, '0);
    send_item(CMD_NEXT_ELEMENT, '0, '0);
    send_item(CMD_NEXT_ROW, '0, '0);
    send_item(CMD_NEXT_ELEMENT, '0, '0);
    send_item(CMD_NEXT_ELEMENT, '0, '0);
    send_item(CMD_NEXT_ELEMENT, '0, '0);
    send_item(CMD_NEXT_ROW, '0, '0);

    // Next row leaves the column position where it was.
    send_item(CMD_RESTART, '0, '0);
    send_item(CMD_NEXT_ELEMENT, '0, '0);
    send_item(CMD_NEXT_ROW, '0, '0);
    send_item(CMD_NEXT_ELEMENT, '0, '0);
    send_item(CMD_RESTART, '0, '0);

    // Drop the column count to zero mid-walk: each row now ends after one
    // element; a fresh restart then finishes at once.
    drain();
    write_config(9'd3, 16'd0, 16'h0001, 16'hFFFF);
    send_item(CMD_NEXT_ELEMENT, '0, '0);
    send_item(CMD_NEXT_ELEMENT, '0, '0);
    send_item(CMD_NEXT_ELEMENT, '0, '0);
    send_item(CMD_NEXT_ELEMENT, '0, '0);
    send_item(CMD_RESTART, '0, '0);
    send_item(CMD_NEXT_ELEMENT, '0, '0);

    // Random walks over a range of settings, extremes first. The row count
    // above the table depth must be clipped to the table.
    run_phase(9'd1, 16'd1, 16'h7FFF, 16'h8000, 80, 4);
    run_phase(9'd4, 16'd3, 16'hFFFF, 16'h0001, 100, 3);
    run_phase(9'd256, 16'd1, 16'h8000, 16'h7FFF, 100, 4);
    run_phase(9'd300, 16'd2, 16'h0001, 16'hFFFF, 80, 0);
    run_phase(9'd5, 16'hFFFF, 16'($urandom()), 16'h8000, 80, 3);
    run_phase(9'd0, 16'd5, 16'($urandom()), 16'($urandom()), 40, 4);
    run_phase(9'd3, 16'd0, 16'($urandom()), 16'($urandom()), 40, 4);
    repeat (6)
      run_phase(9'($urandom_range(1, 8)), 16'($urandom_range(1, 6)),
                16'($urandom()), 16'($urandom()), 110, 3);
    // Hold both sides busy for the closing stretch.
    run_phase(9'($urandom_range(1, 8)), 16'($urandom_range(1, 6)),
              16'($urandom()), 16'($urandom()), 120, 0);

    drain();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/rgig_pkg.sv
rtl/row_gather_index_generator_core.sv
rtl/rgig_checker.sv
tb/tb.sv
